// File: design/key_edge_toggle_cooldown_top_assert.svh
// key_edge_toggle_cooldown_top_assert.svh: assertion macros for the key qualifier checks
// depends on nothing; expects clk and arst_n in the scope that uses the macros
`ifndef KEY_EDGE_TOGGLE_COOLDOWN_TOP_ASSERT_SVH
`define KEY_EDGE_TOGGLE_COOLDOWN_TOP_ASSERT_SVH

// same-cycle implication
`define KETC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define KETC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/ketc_pkg.sv
// ketc_pkg: item types, per-key entry type and fixed widths of the key qualifier
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package ketc_pkg;

	localparam int TIME_BITS = 32;
	localparam int CFG_W     = 32;
	localparam int KEY_IDX_W = 7;
	localparam int MASK_W    = 5;
	localparam int BTN_IDX_W = 3;

	localparam logic FUNC_KEY   = 1'b0;
	localparam logic FUNC_MOUSE = 1'b1;

	typedef struct packed {
		logic                 func;
		logic [KEY_IDX_W-1:0] key_index;
		logic                 key_down;
		logic [MASK_W-1:0]    button_mask;
		logic [TIME_BITS-1:0] time_now;
	} in_item_t;

	typedef struct packed {
		logic                 key_rising;
		logic                 key_toggled;
		logic                 key_held;
		logic                 mouse_clicked;
		logic [BTN_IDX_W-1:0] mouse_button;
	} out_item_t;

	typedef struct packed {
		logic                 level;
		logic                 toggle;
		logic [TIME_BITS-1:0] stamp;
	} key_entry_t;

	typedef struct packed {
		logic                 clicked;
		logic [BTN_IDX_W-1:0] button;
	} mouse_res_t;

endpackage

`default_nettype wire

// File: design/ketc_key_ram.sv
// ketc_key_ram: per-key state memory, one read and one write port, registered read
// depends on ketc_pkg; entries read as zero until first written, with write-to-read bypass
`timescale 1ns / 1ps
`default_nettype none

module ketc_key_ram
	import ketc_pkg::*;
#(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire key_entry_t    wr_data,
	output key_entry_t         rd_data
);

	key_entry_t mem [DEPTH];
	logic [DEPTH-1:0] vld_q;

	key_entry_t mem_rd_q;
	key_entry_t byp_data_q;
	logic       byp_q;
	logic       rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			mem_rd_q   <= mem[rd_addr];
			byp_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			byp_q    <= 1'b0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				byp_q    <= wr_en && (wr_addr == rd_addr);
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	always_comb begin
		if (byp_q) begin
			rd_data = byp_data_q;
		end else if (rd_vld_q) begin
			rd_data = mem_rd_q;
		end else begin
			rd_data = '0;
		end
	end

endmodule

`default_nettype wire

// File: design/ketc_mouse_unit.sv
// ketc_mouse_unit: button scan with global click cooldown and stored mouse state
// depends on ketc_pkg
`timescale 1ns / 1ps
`default_nettype none

module ketc_mouse_unit
	import ketc_pkg::*;
#(
	parameter int NUM_BUTTONS = 5
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 sel,
	input  wire logic                 commit,
	input  wire logic [MASK_W-1:0]    button_mask,
	input  wire logic [TIME_BITS-1:0] time_now,
	input  wire logic [CFG_W-1:0]     cooldown,
	output mouse_res_t                res
);

	localparam int NB = (NUM_BUTTONS < MASK_W) ? NUM_BUTTONS : MASK_W;

	logic [NB-1:0]        lvl_q;
	logic [TIME_BITS-1:0] last_q;
	logic [BTN_IDX_W-1:0] idx_q;

	logic [TIME_BITS-1:0] elapsed;
	logic                 passed;
	logic                 found;
	logic [BTN_IDX_W-1:0] hit_idx;
	logic [NB-1:0]        new_lvl;

	assign elapsed = time_now - last_q;
	assign passed  = TIME_BITS'(elapsed) > TIME_BITS'(cooldown);

	// scan stops at the first accepted rising button
	always_comb begin
		found   = 1'b0;
		hit_idx = idx_q;
		new_lvl = lvl_q;
		for (int b = 0; b < NB; b++) begin
			if (!found) begin
				new_lvl[b] = button_mask[b];
				if (button_mask[b] && !lvl_q[b] && passed) begin
					found   = 1'b1;
					hit_idx = BTN_IDX_W'(b);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q  <= '0;
			last_q <= '0;
			idx_q  <= '0;
		end else if (commit) begin
			lvl_q <= new_lvl;
			if (found) begin
				last_q <= time_now;
				idx_q  <= hit_idx;
			end
		end
	end

	assign res.clicked = sel && found;
	assign res.button  = (sel && found) ? hit_idx : idx_q;

endmodule

`default_nettype wire

// File: design/key_edge_toggle_cooldown_top.sv
// pipeline: an accepted item moves from s1 (s1_valid_q) to out_valid_q, which drives out_valid
// throughput: one item per cycle while not stalled; per-key state read at accept, written
// back from s1, with a bypass in the key memory for back-to-back items on the same key
// reset: clears pipeline valids, cooldown, mouse state and the per-key valid bits at once;
// no clearing pass, items are taken as soon as reset is released
`timescale 1ns / 1ps
`default_nettype none

module key_edge_toggle_cooldown_top
	import ketc_pkg::*;
#(
	parameter int NUM_KEYS    = 128,
	parameter int NUM_BUTTONS = 5
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [CFG_W-1:0] cfg_wr_data,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire in_item_t         in_data,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output out_item_t             out_data
);

	localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

	logic [CFG_W-1:0] cooldown_q;

	logic      s1_valid_q;
	in_item_t  s1_item_s1;
	logic      out_valid_q;
	out_item_t out_item_q;

	logic       adv;
	logic       accept;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic       in_range;
	logic       wr_en;
	key_entry_t ent;
	key_entry_t new_ent;
	logic [TIME_BITS-1:0] elapsed;
	logic       rising;
	logic       flip;
	logic       is_mouse;
	mouse_res_t mres;
	out_item_t  res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cooldown_q <= '0;
		end else if (cfg_wr_en) begin
			cooldown_q <= cfg_wr_data;
		end
	end

	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = s1_valid_q && !adv;
	assign accept   = in_valid && !in_stall;

	assign rd_addr  = AW'({{AW{1'b0}}, in_data.key_index});
	assign wr_addr  = AW'({{AW{1'b0}}, s1_item_s1.key_index});
	assign in_range = 32'(s1_item_s1.key_index) < NUM_KEYS;
	assign is_mouse = s1_item_s1.func == FUNC_MOUSE;

	ketc_key_ram #(
		.DEPTH (NUM_KEYS),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (new_ent),
		.rd_data (ent)
	);

	ketc_mouse_unit #(
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_mouse (
		.clk         (clk),
		.arst_n      (arst_n),
		.sel         (is_mouse),
		.commit      (adv && s1_valid_q && is_mouse),
		.button_mask (s1_item_s1.button_mask),
		.time_now    (s1_item_s1.time_now),
		.cooldown    (cooldown_q),
		.res         (mres)
	);

	// key read-modify-write
	assign elapsed = s1_item_s1.time_now - ent.stamp;
	assign rising  = in_range && s1_item_s1.key_down && !ent.level;
	assign flip    = rising && (TIME_BITS'(elapsed) > TIME_BITS'(cooldown_q));

	always_comb begin
		new_ent.level  = s1_item_s1.key_down;
		new_ent.toggle = ent.toggle ^ flip;
		new_ent.stamp  = flip ? s1_item_s1.time_now : ent.stamp;
	end

	assign wr_en = adv && s1_valid_q && !is_mouse && in_range;

	always_comb begin
		res.mouse_button = mres.button;
		if (is_mouse) begin
			res.key_rising    = 1'b0;
			res.key_toggled   = 1'b0;
			res.key_held      = 1'b0;
			res.mouse_clicked = mres.clicked;
		end else begin
			res.key_rising    = rising;
			res.key_toggled   = in_range && new_ent.toggle;
			res.key_held      = s1_item_s1.key_down;
			res.mouse_clicked = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_item_s1 <= in_data;
		end
		if (adv && s1_valid_q) begin
			out_item_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) begin
				s1_valid_q <= in_valid;
			end
			if (adv) begin
				out_valid_q <= s1_valid_q;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_item_q;

endmodule

`default_nettype wire

// File: design/ketc_checker.sv
// ketc_checker: port-level checks of the key qualifier, bound to the top level
// depends on ketc_pkg and key_edge_toggle_cooldown_top_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "key_edge_toggle_cooldown_top_assert.svh"

module ketc_checker
	import ketc_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_stall,
	input wire logic             out_valid,
	input wire logic             out_stall,
	input wire out_item_t        out_data
);

	`KETC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled output item changed")

	`KETC_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without a stalled output")

	`KETC_ASSERT_NEXT(a_latency, (in_valid && !in_stall) ##1 !out_stall, out_valid, "accepted item not delivered in two cycles")

	`KETC_ASSERT_NOW(a_key_fields, out_valid && out_data.key_rising, out_data.key_held && !out_data.mouse_clicked, "rising edge without held key")

	`KETC_ASSERT_NOW(a_button_range, out_valid, 32'(out_data.mouse_button) < MASK_W, "clicked button index out of range")

endmodule

bind key_edge_toggle_cooldown_top ketc_checker u_ketc_checker (.*);

`default_nettype wire

// File: sim/ketc_checker.sv
// ketc_tb_checker: watches both item channels and the cooldown write port of the key qualifier,
// predicts every result from its own copy of the key and mouse state and compares in order
// depends on ketc_pkg for the item types and widths
`timescale 1ns / 1ps

module ketc_tb_checker
	import ketc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [CFG_W-1:0] cfg_wr_data,
	input  wire logic             in_valid,
	input  wire logic             in_stall,
	input  wire in_item_t         in_data,
	input  wire logic             out_valid,
	input  wire logic             out_stall,
	input  wire out_item_t        out_data,
	output int                    errors,
	output int                    outstanding
);

	localparam int KEY_COUNT = 1 << KEY_IDX_W;

	logic [CFG_W-1:0]     cooldown;
	logic                 key_level [KEY_COUNT];
	logic                 toggle_bit [KEY_COUNT];
	logic [TIME_BITS-1:0] toggle_stamp [KEY_COUNT];
	logic [MASK_W-1:0]    button_level;
	logic [TIME_BITS-1:0] click_stamp;
	logic [BTN_IDX_W-1:0] clicked_button;
	out_item_t            expected_quals [$];

	task automatic report_error(string msg);
		$display("%0t ERROR: %s", $time, msg);
		errors++;
	endtask

	task automatic compare_field(string name, logic [2:0] got, logic [2:0] want);
		if (got !== want)
			report_error($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	function automatic logic cooled(logic [TIME_BITS-1:0] now, logic [TIME_BITS-1:0] stamp);
		logic [TIME_BITS-1:0] elapsed;
		elapsed = now - stamp;
		return elapsed > cooldown;
	endfunction

	function automatic out_item_t predict_qualify(in_item_t it);
		out_item_t r;
		logic      done;
		logic      lvl;
		logic      was;
		r = '0;
		if (it.func == FUNC_KEY) begin
			r.key_held = it.key_down;
			r.key_rising = it.key_down && !key_level[it.key_index];
			if (r.key_rising && cooled(it.time_now, toggle_stamp[it.key_index])) begin
				toggle_bit[it.key_index] = ~toggle_bit[it.key_index];
				toggle_stamp[it.key_index] = it.time_now;
			end
			key_level[it.key_index] = it.key_down;
			r.key_toggled = toggle_bit[it.key_index];
		end else begin
			done = 1'b0;
			for (int b = 0; b < MASK_W; b++) begin
				if (!done) begin
					lvl = it.button_mask[b];
					was = button_level[b];
					button_level[b] = lvl;
					if (lvl && !was && cooled(it.time_now, click_stamp)) begin
						r.mouse_clicked = 1'b1;
						clicked_button = BTN_IDX_W'(b);
						click_stamp = it.time_now;
						done = 1'b1;
					end
				end
			end
		end
		r.mouse_button = clicked_button;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			cooldown = '0;
			for (int k = 0; k < KEY_COUNT; k++) begin
				key_level[k] = 1'b0;
				toggle_bit[k] = 1'b0;
				toggle_stamp[k] = '0;
			end
			button_level = '0;
			click_stamp = '0;
			clicked_button = '0;
			expected_quals.delete();
			errors = 0;
			outstanding = 0;
		end else begin
			if (cfg_wr_en)
				cooldown = cfg_wr_data;
			if (out_valid && !out_stall) begin
				if (expected_quals.size() == 0) begin
					report_error($sformatf("result %0h with none expected", out_data));
				end else begin
					want = expected_quals.pop_front();
					compare_field("key_rising", out_data.key_rising, want.key_rising);
					compare_field("key_toggled", out_data.key_toggled, want.key_toggled);
					compare_field("key_held", out_data.key_held, want.key_held);
					compare_field("mouse_clicked", out_data.mouse_clicked, want.mouse_clicked);
					compare_field("mouse_button", out_data.mouse_button, want.mouse_button);
				end
			end
			if (in_valid && !in_stall)
				expected_quals.push_back(predict_qualify(in_data));
			outstanding = expected_quals.size();
		end
	end

endmodule

// File: sim/key_edge_toggle_cooldown_top_tb.sv
// key_edge_toggle_cooldown_top_tb: drives key and mouse samples and cooldown settings into the
// key qualifier with random idling on both sides; ketc_tb_checker predicts and compares
// depends on ketc_pkg, ketc_tb_checker and key_edge_toggle_cooldown_top
`timescale 1ns / 1ps

module key_edge_toggle_cooldown_top_tb;
	import ketc_pkg::*;

	localparam int HOLD_CYCLES  = 200;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = 10;
	localparam int PHASE_ITEMS  = 100;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_wr_en = 1'b0;
	logic [CFG_W-1:0] cfg_wr_data = '0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	in_item_t         in_data = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	out_item_t        out_data;
	int               errors;
	int               outstanding;
	int               cycles = 0;
	bit               hold_req = 1'b0;
	bit               quiet = 1'b0;
	logic [TIME_BITS-1:0] ticks = '0;

	always #5 clk = ~clk;

	key_edge_toggle_cooldown_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

	ketc_tb_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.errors      (errors),
		.outstanding (outstanding)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// receiver side: random stall bursts, one long hold on request
	initial begin
		int run;
		run = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
				run = 0;
			end else if (quiet) begin
				out_stall <= 1'b0;
			end else if (run > 0) begin
				run--;
			end else begin
				run = $urandom_range(1, 16) - 1;
				out_stall <= ($urandom_range(0, 2) == 0);
			end
		end
	end

	function automatic in_item_t key_item(logic [KEY_IDX_W-1:0] idx, logic down,
		logic [TIME_BITS-1:0] t);
		in_item_t it;
		it = '0;
		it.func = FUNC_KEY;
		it.key_index = idx;
		it.key_down = down;
		it.button_mask = MASK_W'($urandom);
		it.time_now = t;
		return it;
	endfunction

	function automatic in_item_t mouse_item(logic [MASK_W-1:0] mask, logic [TIME_BITS-1:0] t);
		in_item_t it;
		it = '0;
		it.func = FUNC_MOUSE;
		it.key_index = KEY_IDX_W'($urandom);
		it.key_down = 1'($urandom);
		it.button_mask = mask;
		it.time_now = t;
		return it;
	endfunction

	// mostly a few keys pressed and released against a slowly moving tick count
	function automatic in_item_t random_sample();
		logic [KEY_IDX_W-1:0] idx;
		case ($urandom_range(0, 9))
			0: ticks = $urandom;
			1: ticks = ticks + $urandom_range(0, 2000);
			default: ticks = ticks + $urandom_range(0, 12);
		endcase
		if ($urandom_range(0, 2) == 0)
			return mouse_item(MASK_W'($urandom), ticks);
		if ($urandom_range(0, 3) == 0)
			idx = KEY_IDX_W'($urandom);
		else
			idx = KEY_IDX_W'($urandom_range(0, 7));
		return key_item(idx, 1'($urandom), ticks);
	endfunction

	function automatic int sender_gap();
		if (quiet || hold_req)
			return 0;
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(1, 16);
		return 0;
	endfunction

	task automatic send_sample(in_item_t it);
		int gap;
		gap = sender_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic go_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic write_cooldown(logic [CFG_W-1:0] value);
		go_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		logic [CFG_W-1:0] settings [5];
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_cooldown('0);
		// rising edge with zero elapsed ticks does not toggle
		send_sample(key_item(7'd0, 1'b1, 32'd0));
		send_sample(key_item(7'd0, 1'b0, 32'd1));
		send_sample(key_item(7'd0, 1'b1, 32'd1));
		send_sample(key_item(7'd0, 1'b1, 32'd5));
		// elapsed time wraps around
		send_sample(key_item(7'd127, 1'b1, 32'hFFFF_FFFF));
		send_sample(key_item(7'd127, 1'b0, 32'd0));
		send_sample(key_item(7'd127, 1'b1, 32'd3));
		// back-to-back items on one key, unless the sender idles between them
		send_sample(key_item(7'd5, 1'b1, 32'd100));
		send_sample(key_item(7'd5, 1'b0, 32'd100));
		send_sample(key_item(7'd5, 1'b1, 32'd101));
		// first accepted button stops the scan
		send_sample(mouse_item(5'h00, 32'd10));
		send_sample(mouse_item(5'h1F, 32'd10));
		send_sample(mouse_item(5'h1F, 32'd11));
		send_sample(mouse_item(5'h1F, 32'd11));
		send_sample(mouse_item(5'h00, 32'd20));
		send_sample(mouse_item(5'h10, 32'd30));
		send_sample(mouse_item(5'h1F, 32'hFFFF_FFFF));

		write_cooldown(32'd16);
		// elapsed equal to cooldown is not enough
		send_sample(key_item(7'd9, 1'b1, 32'd16));
		send_sample(key_item(7'd9, 1'b0, 32'd17));
		send_sample(key_item(7'd9, 1'b1, 32'd17));
		send_sample(mouse_item(5'h00, 32'd15));
		send_sample(mouse_item(5'h02, 32'd16));

		settings[0] = 32'hFFFF_FFFF;
		settings[1] = $urandom_range(1, 40);
		settings[2] = $urandom;
		settings[3] = '0;
		settings[4] = $urandom_range(1, 8);
		ticks = $urandom;
		for (int p = 0; p < 5; p++) begin
			write_cooldown(settings[p]);
			if (p == 3)
				hold_req = 1'b1;
			if (p == 4)
				quiet = 1'b1;
			repeat (PHASE_ITEMS) send_sample(random_sample());
		end

		go_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+design
design/ketc_pkg.sv
design/ketc_key_ram.sv
design/ketc_mouse_unit.sv
design/key_edge_toggle_cooldown_top.sv
design/ketc_checker.sv
sim/ketc_checker.sv
sim/key_edge_toggle_cooldown_top_tb.sv
